// ----- design/ppts_pkg.sv -----
`default_nettype none

package ppts_pkg;

   // fixed-point format
   localparam int FRAC_BITS = 16;
   localparam int COORD_W   = 32;
   localparam int DIM_W     = 14;
   localparam int PROD_W    = 2 * COORD_W;
   localparam int CLIP_W    = PROD_W + 1 - FRAC_BITS;
   localparam int W_W       = CLIP_W - 1;
   localparam int MAG_W     = CLIP_W;
   localparam int NUM_W     = MAG_W + DIM_W;
   localparam int Q_W       = 32;
   localparam int DIVD_W    = NUM_W + FRAC_BITS - 1;
   localparam int HIGH_W    = DIVD_W - Q_W;
   localparam int CMP_W     = (HIGH_W > W_W) ? HIGH_W : W_W;
   localparam int DIV_STAGES = Q_W;

   // clip w threshold, about 0.001 rounded to nearest, at least one lsb
   localparam longint THRESH_RAW = ((longint'(1) << FRAC_BITS) + 500) / 1000;
   localparam longint THRESH_VAL = (THRESH_RAW < 1) ? 1 : THRESH_RAW;
   localparam logic signed [CLIP_W-1:0] W_THRESH = CLIP_W'(THRESH_VAL);

   localparam logic [Q_W-1:0] MAX_POS = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic [Q_W-1:0] MIN_NEG = {1'b1, {(Q_W-1){1'b0}}};

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1920);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1080);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      ACT_LOAD    = 1'b0,
      ACT_PROJECT = 1'b1
   } action_type;

   typedef enum logic {
      CSR_SCREEN_WIDTH  = 1'b0,
      CSR_SCREEN_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      action_type          action;
      logic [3:0]          coef_index;
      logic signed [31:0]  coef_value;
      logic signed [31:0]  point_x;
      logic signed [31:0]  point_y;
      logic signed [31:0]  point_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  screen_x;
      logic signed [31:0]  screen_y;
      logic signed [31:0]  depth;
      logic                behind_camera;
      logic                saturated;
   } rsp_type;

   // classified point handed from front to back
   typedef struct packed {
      logic               behind;
      logic [MAG_W-1:0]   mag_x;
      logic               neg_x;
      logic [MAG_W-1:0]   mag_y;
      logic               neg_y;
      logic [W_W-1:0]     w;
      logic [31:0]        depth;
      logic               dep_sat;
   } job_type;

endpackage

`default_nettype wire

// ----- design/perspective_project_to_screen.sv -----
`default_nettype none

// throughput: one request per cycle while no back-pressure holds it; the 32-stage quotient
//   pipeline and the three-stage matrix front run in parallel, decoupled by a four-entry queue
// coefficient loads produce no result
// reset: synchronous, clears the view matrix to zero, viewport to 1920 x 1080,
//   and empties all queues and pipelines
module perspective_project_to_screen (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   input  wire ppts_pkg::req_type              req_data,
   output logic                                req_full,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output ppts_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_we,
   input  wire ppts_pkg::csr_index_type        csr_index,
   input  wire logic [ppts_pkg::DIM_W-1:0]     csr_wdata
);

   // viewport size registers
   logic [ppts_pkg::DIM_W-1:0] width_ff;
   logic [ppts_pkg::DIM_W-1:0] height_ff;

   // front to back queue
   logic              job_wr;
   logic              job_full;
   logic              job_rd;
   logic              job_empty;
   ppts_pkg::job_type job_wr_data;
   ppts_pkg::job_type job_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ppts_pkg::WIDTH_RESET;
         height_ff <= ppts_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            ppts_pkg::CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata;
            ppts_pkg::CSR_SCREEN_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // front: coefficient store, clip-space transform, behind test
   ppts_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .job_wr   (job_wr),
      .job_data (job_wr_data),
      .job_full (job_full)
   );

   // short queue so front and back stall independently
   ppts_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (job_wr),
      .wr_data (job_wr_data),
      .full    (job_full),
      .rd      (job_rd),
      .rd_data (job_rd_data),
      .empty   (job_empty)
   );

   // back: viewport scale, pipelined divide by w, clamp, result queue
   ppts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .width     (width_ff),
      .height    (height_ff),
      .job_empty (job_empty),
      .job_data  (job_rd_data),
      .job_rd    (job_rd),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- design/ppts_front.sv -----
`default_nettype none

module ppts_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   input  wire ppts_pkg::req_type req_data,
   output logic                   req_full,
   output logic                   job_wr,
   output ppts_pkg::job_type      job_data,
   input  wire logic              job_full
);

   localparam logic [1:0] CLIP_ROW [3] = '{2'd0, 2'd1, 2'd3};

   logic signed [31:0] mtx_ff [16];

   logic                                  en;
   logic                                  accept;
   logic signed [31:0]                    coord [3];
   logic signed [ppts_pkg::PROD_W-1:0]    prod_in [9];
   logic signed [ppts_pkg::PROD_W-1:0]    prod_ff [9];
   logic signed [31:0]                    col3_in [3];
   logic signed [31:0]                    col3_ff [3];
   logic                                  v1_ff;
   logic signed [ppts_pkg::CLIP_W-1:0]    clip_in [3];
   logic signed [ppts_pkg::CLIP_W-1:0]    clip_ff [3];
   logic                                  v2_ff;
   logic signed [ppts_pkg::CLIP_W:0]      nx;
   logic signed [ppts_pkg::CLIP_W:0]      ny;
   logic signed [ppts_pkg::CLIP_W:0]      nx_neg;
   logic signed [ppts_pkg::CLIP_W:0]      ny_neg;
   ppts_pkg::job_type                     job_in;
   ppts_pkg::job_type                     job_ff;
   logic                                  v3_ff;

   assign en       = !(v3_ff && job_full);
   assign req_full = !en;
   assign accept   = req_push && en;
   assign job_wr   = v3_ff && en;
   assign job_data = job_ff;

   // coefficient store
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) mtx_ff[i] <= '0;
      end else if (accept && req_data.action == ppts_pkg::ACT_LOAD) begin
         mtx_ff[req_data.coef_index] <= req_data.coef_value;
      end
   end

   // rows 0, 1 and 3 times the point
   always_comb begin
      coord[0] = req_data.point_x;
      coord[1] = req_data.point_y;
      coord[2] = req_data.point_z;
      for (int k = 0; k < 3; k++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[k*3+c] = mtx_ff[{CLIP_ROW[k], 2'(c)}] * coord[c];
         end
         col3_in[k] = mtx_ff[{CLIP_ROW[k], 2'd3}];
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         clip_in[k] = ppts_pkg::CLIP_W'(prod_ff[k*3]   >>> ppts_pkg::FRAC_BITS)
                    + ppts_pkg::CLIP_W'(prod_ff[k*3+1] >>> ppts_pkg::FRAC_BITS)
                    + ppts_pkg::CLIP_W'(prod_ff[k*3+2] >>> ppts_pkg::FRAC_BITS)
                    + ppts_pkg::CLIP_W'(col3_ff[k]);
      end
   end

   // classify: behind test, axis numerators, depth clamp
   always_comb begin
      nx = (ppts_pkg::CLIP_W+1)'(clip_ff[2]) + (ppts_pkg::CLIP_W+1)'(clip_ff[0]);
      ny = (ppts_pkg::CLIP_W+1)'(clip_ff[2]) - (ppts_pkg::CLIP_W+1)'(clip_ff[1]);
      nx_neg = -nx;
      ny_neg = -ny;
      job_in.behind  = clip_ff[2] < ppts_pkg::W_THRESH;
      job_in.neg_x   = nx[ppts_pkg::CLIP_W];
      job_in.neg_y   = ny[ppts_pkg::CLIP_W];
      job_in.mag_x   = nx[ppts_pkg::CLIP_W] ? nx_neg[ppts_pkg::MAG_W-1:0]
                                            : nx[ppts_pkg::MAG_W-1:0];
      job_in.mag_y   = ny[ppts_pkg::CLIP_W] ? ny_neg[ppts_pkg::MAG_W-1:0]
                                            : ny[ppts_pkg::MAG_W-1:0];
      job_in.w       = clip_ff[2][ppts_pkg::W_W-1:0];
      job_in.dep_sat = |clip_ff[2][ppts_pkg::CLIP_W-1:31];
      job_in.depth   = job_in.dep_sat ? ppts_pkg::MAX_POS : clip_ff[2][31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= accept && req_data.action == ppts_pkg::ACT_PROJECT;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         col3_ff <= col3_in;
         clip_ff <= clip_in;
         job_ff  <= job_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/ppts_queue.sv -----
`default_nettype none

module ppts_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr,
   input  wire ppts_pkg::job_type wr_data,
   output logic                   full,
   input  wire logic              rd,
   output ppts_pkg::job_type      rd_data,
   output logic                   empty
);

   ppts_pkg::job_type                 mem_ff [ppts_pkg::QUEUE_DEPTH];
   logic [ppts_pkg::QPTR_W-1:0]       wptr_ff;
   logic [ppts_pkg::QPTR_W-1:0]       rptr_ff;
   logic [ppts_pkg::QCNT_W-1:0]       cnt_ff;
   logic [ppts_pkg::QCNT_W-1:0]       cnt_in;

   assign full    = cnt_ff == ppts_pkg::QCNT_W'(ppts_pkg::QUEUE_DEPTH);
   assign empty   = cnt_ff == '0;
   assign rd_data = mem_ff[rptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (wr && !rd) cnt_in = cnt_ff + 1'b1;
      if (rd && !wr) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (wr) wptr_ff <= wptr_ff + 1'b1;
         if (rd) rptr_ff <= rptr_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wptr_ff] <= wr_data;
   end

endmodule

`default_nettype wire

// ----- design/ppts_back.sv -----
`default_nettype none

module ppts_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [ppts_pkg::DIM_W-1:0]  width,
   input  wire logic [ppts_pkg::DIM_W-1:0]  height,
   input  wire logic                        job_empty,
   input  wire ppts_pkg::job_type           job_data,
   output logic                             job_rd,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output ppts_pkg::rsp_type                rsp_data
);

   typedef struct packed {
      logic [ppts_pkg::W_W-1:0]  r_x;
      logic [ppts_pkg::Q_W-1:0]  dq_x;
      logic                      ovf_x;
      logic                      neg_x;
      logic [ppts_pkg::W_W-1:0]  r_y;
      logic [ppts_pkg::Q_W-1:0]  dq_y;
      logic                      ovf_y;
      logic                      neg_y;
      logic [ppts_pkg::W_W-1:0]  w;
      logic                      behind;
      logic [31:0]               depth;
      logic                      dep_sat;
   } div_type;

   // one restoring step: shift in next dividend bit, subtract if it fits
   function automatic logic [ppts_pkg::W_W+ppts_pkg::Q_W-1:0] div_step(
      input logic [ppts_pkg::W_W-1:0] r,
      input logic [ppts_pkg::Q_W-1:0] dq,
      input logic [ppts_pkg::W_W-1:0] w
   );
      logic [ppts_pkg::W_W:0] rr;
      logic [ppts_pkg::W_W:0] diff;
      rr   = {r, dq[ppts_pkg::Q_W-1]};
      diff = rr - {1'b0, w};
      if (rr >= {1'b0, w}) begin
         return {diff[ppts_pkg::W_W-1:0], dq[ppts_pkg::Q_W-2:0], 1'b1};
      end
      return {rr[ppts_pkg::W_W-1:0], dq[ppts_pkg::Q_W-2:0], 1'b0};
   endfunction

   // sign and clamp one axis, returns {sat, value}
   function automatic logic [ppts_pkg::Q_W:0] axis_out(
      input logic [ppts_pkg::Q_W-1:0] q,
      input logic                     neg,
      input logic                     ovf
   );
      logic over;
      over = ovf || (neg ? (q > ppts_pkg::MIN_NEG) : q[ppts_pkg::Q_W-1]);
      if (over) begin
         return {1'b1, neg ? ppts_pkg::MIN_NEG : ppts_pkg::MAX_POS};
      end
      return {1'b0, neg ? -q : q};
   endfunction

   logic                                b_en;
   logic                                b0_valid_ff;
   ppts_pkg::job_type                   b0_job_ff;
   logic [ppts_pkg::NUM_W-1:0]          num_x_ff;
   logic [ppts_pkg::NUM_W-1:0]          num_y_ff;
   logic [ppts_pkg::DIVD_W-1:0]         divd_x;
   logic [ppts_pkg::DIVD_W-1:0]         divd_y;
   logic [ppts_pkg::CMP_W-1:0]          hi_x;
   logic [ppts_pkg::CMP_W-1:0]          hi_y;
   logic [ppts_pkg::CMP_W-1:0]          w_ext;
   div_type                             stage_in [ppts_pkg::DIV_STAGES+1];
   div_type                             stage_ff [ppts_pkg::DIV_STAGES+1];
   logic                                dv_ff    [ppts_pkg::DIV_STAGES+1];
   div_type                             last;
   logic [ppts_pkg::Q_W:0]              ax_x;
   logic [ppts_pkg::Q_W:0]              ax_y;
   ppts_pkg::rsp_type                   out_in;
   ppts_pkg::rsp_type                   o_mem_ff [2];
   logic                                o_wptr_ff;
   logic                                o_rptr_ff;
   logic [1:0]                          o_cnt_ff;
   logic [1:0]                          o_cnt_in;
   logic                                o_full;
   logic                                o_wr;
   logic                                o_rd;

   assign last   = stage_ff[ppts_pkg::DIV_STAGES];
   assign o_full = o_cnt_ff == 2'd2;
   assign b_en   = !(dv_ff[ppts_pkg::DIV_STAGES] && o_full);
   assign job_rd = b_en && !job_empty;
   assign o_wr   = dv_ff[ppts_pkg::DIV_STAGES] && b_en;
   assign o_rd   = rsp_pop && !rsp_empty;

   // scale stage: numerator magnitude times viewport size
   always_ff @(posedge clock) begin
      if (b_en) begin
         b0_job_ff <= job_data;
         num_x_ff  <= ppts_pkg::NUM_W'(job_data.mag_x) * ppts_pkg::NUM_W'(width);
         num_y_ff  <= ppts_pkg::NUM_W'(job_data.mag_y) * ppts_pkg::NUM_W'(height);
      end
   end

   // divider setup: overflow test and first partial remainder
   always_comb begin
      divd_x = ppts_pkg::DIVD_W'(num_x_ff) << (ppts_pkg::FRAC_BITS - 1);
      divd_y = ppts_pkg::DIVD_W'(num_y_ff) << (ppts_pkg::FRAC_BITS - 1);
      hi_x   = ppts_pkg::CMP_W'(divd_x[ppts_pkg::DIVD_W-1:ppts_pkg::Q_W]);
      hi_y   = ppts_pkg::CMP_W'(divd_y[ppts_pkg::DIVD_W-1:ppts_pkg::Q_W]);
      w_ext  = ppts_pkg::CMP_W'(b0_job_ff.w);
      stage_in[0].r_x     = hi_x[ppts_pkg::W_W-1:0];
      stage_in[0].dq_x    = divd_x[ppts_pkg::Q_W-1:0];
      stage_in[0].ovf_x   = hi_x >= w_ext;
      stage_in[0].neg_x   = b0_job_ff.neg_x;
      stage_in[0].r_y     = hi_y[ppts_pkg::W_W-1:0];
      stage_in[0].dq_y    = divd_y[ppts_pkg::Q_W-1:0];
      stage_in[0].ovf_y   = hi_y >= w_ext;
      stage_in[0].neg_y   = b0_job_ff.neg_y;
      stage_in[0].w       = b0_job_ff.w;
      stage_in[0].behind  = b0_job_ff.behind;
      stage_in[0].depth   = b0_job_ff.depth;
      stage_in[0].dep_sat = b0_job_ff.dep_sat;
   end

   for (genvar g = 0; g < ppts_pkg::DIV_STAGES; g++) begin : g_div
      always_comb begin
         stage_in[g+1] = stage_ff[g];
         {stage_in[g+1].r_x, stage_in[g+1].dq_x} =
            div_step(stage_ff[g].r_x, stage_ff[g].dq_x, stage_ff[g].w);
         {stage_in[g+1].r_y, stage_in[g+1].dq_y} =
            div_step(stage_ff[g].r_y, stage_ff[g].dq_y, stage_ff[g].w);
      end
   end

   always_ff @(posedge clock) begin
      if (b_en) begin
         for (int i = 0; i <= ppts_pkg::DIV_STAGES; i++) stage_ff[i] <= stage_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff <= 1'b0;
         for (int i = 0; i <= ppts_pkg::DIV_STAGES; i++) dv_ff[i] <= 1'b0;
      end else if (b_en) begin
         b0_valid_ff <= job_rd;
         dv_ff[0]    <= b0_valid_ff;
         for (int i = 1; i <= ppts_pkg::DIV_STAGES; i++) dv_ff[i] <= dv_ff[i-1];
      end
   end

   // result formatting
   always_comb begin
      ax_x = axis_out(last.dq_x, last.neg_x, last.ovf_x);
      ax_y = axis_out(last.dq_y, last.neg_y, last.ovf_y);
      if (last.behind) begin
         out_in = '0;
         out_in.behind_camera = 1'b1;
      end else begin
         out_in.screen_x      = ax_x[ppts_pkg::Q_W-1:0];
         out_in.screen_y      = ax_y[ppts_pkg::Q_W-1:0];
         out_in.depth         = last.depth;
         out_in.behind_camera = 1'b0;
         out_in.saturated     = ax_x[ppts_pkg::Q_W] | ax_y[ppts_pkg::Q_W] | last.dep_sat;
      end
   end

   // two-entry result queue
   assign rsp_empty = o_cnt_ff == 2'd0;
   assign rsp_data  = o_mem_ff[o_rptr_ff];

   always_comb begin
      o_cnt_in = o_cnt_ff;
      if (o_wr && !o_rd) o_cnt_in = o_cnt_ff + 2'd1;
      if (o_rd && !o_wr) o_cnt_in = o_cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_wptr_ff <= 1'b0;
         o_rptr_ff <= 1'b0;
         o_cnt_ff  <= 2'd0;
      end else begin
         if (o_wr) o_wptr_ff <= !o_wptr_ff;
         if (o_rd) o_rptr_ff <= !o_rptr_ff;
         o_cnt_ff <= o_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (o_wr) o_mem_ff[o_wptr_ff] <= out_in;
   end

   a_behind_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.behind_camera) |->
         (rsp_data.screen_x == '0 && rsp_data.screen_y == '0 &&
          rsp_data.depth == '0 && !rsp_data.saturated))
      else $error("behind result carries nonzero data");

   a_out_count: assert property (@(posedge clock) disable iff (reset)
      o_cnt_ff != 2'd3)
      else $error("result queue count out of range");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (dv_ff[ppts_pkg::DIV_STAGES] && !b_en) |=> dv_ff[ppts_pkg::DIV_STAGES])
      else $error("stalled divider result lost");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam int ITEMS_PER_PHASE = 300;
   localparam int SETTLE_CYCLES   = 60;
   localparam longint CYCLE_LIMIT = 400000;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_push = 1'b0;
   ppts_pkg::req_type           req_data = '0;
   logic                        req_full;
   logic                        rsp_empty;
   logic                        rsp_pop = 1'b0;
   ppts_pkg::rsp_type           rsp_data;
   logic                        csr_we = 1'b0;
   ppts_pkg::csr_index_type     csr_index = ppts_pkg::CSR_SCREEN_WIDTH;
   logic [ppts_pkg::DIM_W-1:0]  csr_wdata = '0;

   // requests waiting for the driver, and screen results still to arrive
   ppts_pkg::req_type pending_requests[$];
   ppts_pkg::rsp_type expected_points[$];

   // predictor state: view matrix and viewport
   longint      view_coef[16];
   int unsigned view_width;
   int unsigned view_height;

   longint cycle_count = 0;
   int     error_count = 0;

   perspective_project_to_screen dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // one matrix row times (x, y, z, 1), each product floored to the format
   function automatic longint clip_of_row(int row, longint x, longint y, longint z);
      int b;
      b = row * 4;
      return ((view_coef[b] * x) >>> ppts_pkg::FRAC_BITS) +
             ((view_coef[b+1] * y) >>> ppts_pkg::FRAC_BITS) +
             ((view_coef[b+2] * z) >>> ppts_pkg::FRAC_BITS) + view_coef[b+3];
   endfunction

   // |n| * dim * 2^(FRAC_BITS-1) / w, truncated, signed like n; msb is the clamp flag
   function automatic logic [32:0] screen_axis(longint n, longint w, int unsigned dim);
      logic [127:0] mag;
      logic [127:0] q;
      logic [127:0] limit;
      logic [31:0]  val;
      logic         clamp;
      if (dim == 0) return '0;
      clamp = 1'b0;
      mag = 128'((n < 0) ? -n : n);
      q = ((mag * 128'(dim)) << (ppts_pkg::FRAC_BITS - 1)) / 128'(w);
      limit = (n < 0) ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (q > limit) begin
         q = limit;
         clamp = 1'b1;
      end
      val = q[31:0];
      if (n < 0) val = -val;
      return {clamp, val};
   endfunction

   function automatic ppts_pkg::rsp_type project_point(ppts_pkg::req_type r);
      longint cx, cy, cw;
      logic [32:0] ax, ay;
      ppts_pkg::rsp_type o;
      o = '0;
      cx = clip_of_row(0, r.point_x, r.point_y, r.point_z);
      cy = clip_of_row(1, r.point_x, r.point_y, r.point_z);
      cw = clip_of_row(3, r.point_x, r.point_y, r.point_z);
      if (cw < ppts_pkg::THRESH_VAL) begin
         o.behind_camera = 1'b1;
         return o;
      end
      ax = screen_axis(cw + cx, cw, view_width);
      ay = screen_axis(cw - cy, cw, view_height);
      o.screen_x = ax[31:0];
      o.screen_y = ay[31:0];
      o.saturated = ax[32] | ay[32];
      if (cw > 64'sh7FFF_FFFF) begin
         o.depth = 32'h7FFF_FFFF;
         o.saturated = 1'b1;
      end else begin
         o.depth = cw[31:0];
      end
      return o;
   endfunction

   // cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // driver: bursts of requests with random gaps, changes on the falling edge
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (gap_left > 0) begin
         gap_left = gap_left - 1;
         req_push <= 1'b0;
      end else if (pending_requests.size() > 0) begin
         req_push <= 1'b1;
         req_data <= pending_requests[0];
         if (burst_left > 0) burst_left = burst_left - 1;
         if (burst_left == 0) begin
            // long runs without gaps now and then
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
            gap_left = $urandom_range(0, 6);
         end
      end else begin
         req_push <= 1'b0;
      end
   end

   // accepted request: update the matrix or predict a screen point
   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         if (req_data.action == ppts_pkg::ACT_LOAD)
            view_coef[req_data.coef_index] = longint'(req_data.coef_value);
         else
            expected_points.push_back(project_point(req_data));
         void'(pending_requests.pop_front());
      end
   end

   // receiver: own stall pattern, plus one long hold-off to fill the block
   int pop_mode = 0;
   int mode_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         // hold off once while plenty of requests are still queued
         if (!hold_done && pending_requests.size() > 150) begin
            hold_left = 400;
            hold_done = 1'b1;
         end
         if (mode_left == 0) begin
            pop_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(10, 80);
         end
         mode_left = mode_left - 1;
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_pop <= 1'b0;
         end else begin
            case (pop_mode)
               0: rsp_pop <= 1'b1;
               1: rsp_pop <= 1'($urandom_range(0, 1));
               default: rsp_pop <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // monitor: compare each accepted result with the oldest expected point
   always @(posedge clock) begin
      ppts_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_points.size() == 0) begin
            $error("unexpected result %h", rsp_data);
            error_count = error_count + 1;
         end else begin
            want = expected_points.pop_front();
            if (rsp_data.screen_x !== want.screen_x) begin
               $error("screen_x expected %h actual %h", want.screen_x, rsp_data.screen_x);
               error_count = error_count + 1;
            end
            if (rsp_data.screen_y !== want.screen_y) begin
               $error("screen_y expected %h actual %h", want.screen_y, rsp_data.screen_y);
               error_count = error_count + 1;
            end
            if (rsp_data.depth !== want.depth) begin
               $error("depth expected %h actual %h", want.depth, rsp_data.depth);
               error_count = error_count + 1;
            end
            if (rsp_data.behind_camera !== want.behind_camera) begin
               $error("behind_camera expected %b actual %b",
                      want.behind_camera, rsp_data.behind_camera);
               error_count = error_count + 1;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated expected %b actual %b", want.saturated, rsp_data.saturated);
               error_count = error_count + 1;
            end
         end
      end
   end

   // random fixed-point value of random magnitude, extremes now and then
   function automatic logic [31:0] random_fixed(int min_shift, int max_shift);
      case ($urandom_range(0, 11))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return '0;
         default: return $signed($urandom) >>> $urandom_range(min_shift, max_shift);
      endcase
   endfunction

   task automatic queue_load(int idx, logic [31:0] value);
      ppts_pkg::req_type r;
      r = '0;
      r.action = ppts_pkg::ACT_LOAD;
      r.coef_index = idx[3:0];
      r.coef_value = value;
      // point fields are don't-care on a load
      r.point_x = $urandom;
      r.point_y = $urandom;
      r.point_z = $urandom;
      pending_requests.push_back(r);
   endtask

   task automatic queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      ppts_pkg::req_type r;
      r.action = ppts_pkg::ACT_PROJECT;
      // coefficient fields are don't-care on a project
      r.coef_index = 4'($urandom);
      r.coef_value = $urandom;
      r.point_x = x;
      r.point_y = y;
      r.point_z = z;
      pending_requests.push_back(r);
   endtask

   task automatic wait_idle();
      while (pending_requests.size() > 0 || expected_points.size() > 0 || req_push)
         @(posedge clock);
      // trailing loads make no result but may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_viewport(logic [ppts_pkg::DIM_W-1:0] w,
                               logic [ppts_pkg::DIM_W-1:0] h);
      wait_idle();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= ppts_pkg::CSR_SCREEN_WIDTH;
      csr_wdata <= w;
      @(negedge clock);
      csr_index <= ppts_pkg::CSR_SCREEN_HEIGHT;
      csr_wdata <= h;
      @(negedge clock);
      csr_we <= 1'b0;
      view_width = 32'(w);
      view_height = 32'(h);
   endtask

   // mostly well-formed: fresh matrix with w in front, then a run of points
   task automatic random_phase(int count);
      int sent;
      int k;
      sent = 0;
      while (sent < count) begin
         for (k = 0; k < 16; k++) begin
            if (k == 15 && $urandom_range(0, 3) != 0)
               queue_load(k, $urandom_range(66, 32'h00FF_FFFF));
            else
               queue_load(k, random_fixed(8, 22));
         end
         sent += 16;
         repeat ($urandom_range(10, 30)) begin
            if ($urandom_range(0, 9) == 0)
               queue_load($urandom_range(0, 15), random_fixed(0, 31));
            else
               queue_point(random_fixed(0, 31), random_fixed(0, 31), random_fixed(0, 31));
            sent++;
         end
      end
   endtask

   initial begin
      view_width = 1920;
      view_height = 1080;
      foreach (view_coef[i]) view_coef[i] = 0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: all-zero matrix gives behind camera
      queue_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      // simple perspective: x, y unit scale, w taken from z
      queue_load(0, 32'h0001_0000);
      queue_load(5, 32'h0001_0000);
      queue_load(14, 32'h0001_0000);
      queue_point(32'h0, 32'h0, 32'h0001_0000);
      queue_point(32'h0000_8000, 32'hFFFF_8000, 32'h0002_0000);
      queue_point(32'h0, 32'h0, 32'd65);            // just under the threshold
      queue_point(32'h0, 32'h0, 32'd66);            // right at the threshold
      queue_point(32'h0, 32'h0, 32'hFFFF_FFFF);     // negative w
      queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd66);   // screen clamp
      queue_point(32'h8000_0000, 32'h7FFF_FFFF, 32'd66);
      queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_load(15, 32'h7FFF_FFFF);
      queue_point(32'h0, 32'h0, 32'h7FFF_FFFF);     // depth clamp
      queue_load(12, 32'h8000_0000);
      queue_load(3, 32'h8000_0000);
      queue_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      queue_load(7, 32'h7FFF_FFFF);
      queue_point(32'hFFFF_FFFF, 32'h0, 32'h0);
      random_phase(ITEMS_PER_PHASE);

      set_viewport(14'd1, 14'd1);
      random_phase(ITEMS_PER_PHASE);
      set_viewport(14'd8192, 14'd8192);
      random_phase(ITEMS_PER_PHASE);
      // zero size on one axis, all bits set on the other
      set_viewport(14'h3FFF, 14'd0);
      random_phase(ITEMS_PER_PHASE / 2);
      set_viewport(14'd0, 14'h3FFF);
      random_phase(ITEMS_PER_PHASE / 2);
      set_viewport(14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)));
      random_phase(ITEMS_PER_PHASE);

      wait_idle();
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- files.f -----
design/ppts_pkg.sv
design/ppts_front.sv
design/ppts_queue.sv
design/ppts_back.sv
design/perspective_project_to_screen.sv
tb/sv/testbench.sv
